// ===== hdl/rlx_pkg.sv =====
`default_nettype none
package rlx_pkg;

   localparam int unsigned SIZE_WIDTH = 24;
   localparam int unsigned FIXED_SKIP = 16;
   localparam int unsigned SKIP_WIDTH = 20;
   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned ID_WIDTH = 64;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_BYTE = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_STR_LO,
      PH_STR_HI,
      PH_STR_SKIP,
      PH_FIXED,
      PH_SKC_LO,
      PH_SKC_HI,
      PH_SKIP_IDS,
      PH_LST_LO,
      PH_LST_HI,
      PH_LST_IDS
   } rlx_phase_type;

   typedef struct packed {
      logic        req_type;
      logic        record_present;
      logic [23:0] record_size;
      logic [7:0]  data_byte;
   } rlx_req_type;

   typedef struct packed {
      logic [63:0] item_id;
      logic        id_valid;
      logic        done_res;
      logic        found;
   } rlx_rsp_type;

endpackage
`default_nettype wire

// ===== hdl/rlx_parse.sv =====
`default_nettype none
module rlx_parse (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 step,
   input  wire rlx_pkg::rlx_req_type req,
   output logic                has_rsp,
   output rlx_pkg::rlx_rsp_type rsp
);
   import rlx_pkg::*;

   rlx_phase_type          phase_ff, phase_in;
   logic [SIZE_WIDTH-1:0]  bytes_left_ff, bytes_left_in;
   logic [SKIP_WIDTH-1:0]  skip_count_ff, skip_count_in;
   logic [7:0]             low_byte_ff, low_byte_in;
   logic [COUNT_WIDTH-1:0] ids_left_ff, ids_left_in;
   logic [ID_WIDTH-1:0]    id_accum_ff, id_accum_in;
   logic [2:0]             byte_index_ff, byte_index_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= '0;
         skip_count_ff <= '0;
         low_byte_ff   <= '0;
         ids_left_ff   <= '0;
         id_accum_ff   <= '0;
         byte_index_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         skip_count_ff <= skip_count_in;
         low_byte_ff   <= low_byte_in;
         ids_left_ff   <= ids_left_in;
         id_accum_ff   <= id_accum_in;
         byte_index_ff <= byte_index_in;
      end
   end

   always_comb begin
      logic [SIZE_WIDTH-1:0]  bl;
      logic [SIZE_WIDTH-1:0]  word_ext;
      logic [SKIP_WIDTH-1:0]  sc;
      logic [COUNT_WIDTH-1:0] word;
      logic [COUNT_WIDTH-1:0] ids_dec;
      logic fail, ok, go_fixed, go_skc, go_lst;

      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      skip_count_in = skip_count_ff;
      low_byte_in   = low_byte_ff;
      ids_left_in   = ids_left_ff;
      id_accum_in   = id_accum_ff;
      byte_index_in = byte_index_ff;
      has_rsp       = 1'b0;
      rsp           = '0;
      fail          = 1'b0;
      ok            = 1'b0;
      go_fixed      = 1'b0;
      go_skc        = 1'b0;
      go_lst        = 1'b0;

      bl       = bytes_left_ff - SIZE_WIDTH'(bytes_left_ff != '0);
      word     = {req.data_byte, low_byte_ff};
      word_ext = SIZE_WIDTH'(word);
      sc       = skip_count_ff - SKIP_WIDTH'(skip_count_ff != '0);
      ids_dec  = ids_left_ff - COUNT_WIDTH'(ids_left_ff != '0);

      if (step) begin
         if (req.req_type == REQ_START) begin
            if (!req.record_present) begin
               fail = 1'b1;
            end else begin
               bytes_left_in = req.record_size[SIZE_WIDTH-1:0];
               skip_count_in = '0;
               low_byte_in   = '0;
               ids_left_in   = '0;
               id_accum_in   = '0;
               byte_index_in = '0;
               if (req.record_size[SIZE_WIDTH-1:0] < SIZE_WIDTH'(2)) begin
                  fail = 1'b1;
               end else begin
                  phase_in = PH_STR_LO;
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            bytes_left_in = bl;
            unique case (phase_ff)
               PH_STR_LO, PH_SKC_LO, PH_LST_LO: begin
                  low_byte_in = req.data_byte;
                  phase_in    = rlx_phase_type'(phase_ff + 4'd1);
               end
               PH_STR_HI: begin
                  if (word_ext > bl) begin
                     fail = 1'b1;
                  end else if (word == '0) begin
                     go_fixed = 1'b1;
                  end else begin
                     skip_count_in = SKIP_WIDTH'(word);
                     phase_in      = PH_STR_SKIP;
                  end
               end
               PH_STR_SKIP: begin
                  skip_count_in = sc;
                  go_fixed      = (sc == '0);
               end
               PH_FIXED: begin
                  skip_count_in = sc;
                  go_skc        = (sc == '0);
               end
               PH_SKIP_IDS: begin
                  skip_count_in = sc;
                  go_lst        = (sc == '0);
               end
               PH_SKC_HI: begin
                  if (word_ext > (bl >> 3)) begin
                     fail = 1'b1;
                  end else if (word == '0) begin
                     go_lst = 1'b1;
                  end else begin
                     skip_count_in = SKIP_WIDTH'({word, 3'b000});
                     phase_in      = PH_SKIP_IDS;
                  end
               end
               PH_LST_HI: begin
                  if (word_ext > (bl >> 3)) begin
                     fail = 1'b1;
                  end else if (word == '0) begin
                     ok = 1'b1;
                  end else begin
                     ids_left_in   = word;
                     id_accum_in   = '0;
                     byte_index_in = '0;
                     phase_in      = PH_LST_IDS;
                  end
               end
               PH_LST_IDS: begin
                  // lanes are cleared per id, so a lane write is the same as an or
                  if (byte_index_ff == 3'd7) begin
                     has_rsp       = 1'b1;
                     rsp.item_id   = {req.data_byte, id_accum_ff[55:0]};
                     rsp.id_valid  = 1'b1;
                     rsp.done_res  = (ids_dec == '0);
                     rsp.found     = (ids_dec == '0);
                     ids_left_in   = ids_dec;
                     id_accum_in   = '0;
                     byte_index_in = '0;
                     if (ids_dec == '0) begin
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     id_accum_in[byte_index_ff*8 +: 8] = req.data_byte;
                     byte_index_in = byte_index_ff + 3'd1;
                  end
               end
               default: begin
               end
            endcase

            if (go_fixed) begin
               if (SIZE_WIDTH'(FIXED_SKIP) > bl) begin
                  fail = 1'b1;
               end else if (FIXED_SKIP == 0) begin
                  go_skc = 1'b1;
               end else begin
                  skip_count_in = SKIP_WIDTH'(FIXED_SKIP);
                  phase_in      = PH_FIXED;
               end
            end
            // a count field needs two bytes left
            if (go_skc) begin
               if (bl < SIZE_WIDTH'(2)) begin
                  fail = 1'b1;
               end else begin
                  phase_in = PH_SKC_LO;
               end
            end
            if (go_lst) begin
               if (bl < SIZE_WIDTH'(2)) begin
                  fail = 1'b1;
               end else begin
                  phase_in = PH_LST_LO;
               end
            end
         end

         if (fail || ok) begin
            phase_in     = PH_IDLE;
            has_rsp      = 1'b1;
            rsp.item_id  = '0;
            rsp.id_valid = 1'b0;
            rsp.done_res = 1'b1;
            rsp.found    = ok;
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/record_id_list_extractor_core.sv =====
`default_nettype none
// Pulls the second id list out of a record that streams in one byte per item. A start
// item (req_type 0) opens a record and gives its size; byte items (req_type 1) then
// walk the string length, string, fixed block, first id list and second count, and
// every completed id of the second list comes out as one result item. A record that
// is absent or runs short ends with done_res set and found clear on the item that
// reveals it; the last id carries done_res and found set, and an empty list gives a
// done/found item with no id. The parse state updates in the cycle the item is accepted
// and any result lands in the output register, so an item is taken every cycle as long
// as the output register is empty or being drained.
module record_id_list_extractor_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire rlx_pkg::rlx_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rlx_pkg::rlx_rsp_type rsp_payload
);
   import rlx_pkg::*;

   logic        step;
   logic        has_rsp;
   rlx_rsp_type rsp_next;
   logic        rsp_valid_ff, rsp_valid_in;
   rlx_rsp_type rsp_payload_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   rlx_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .req     (req_payload),
      .has_rsp (has_rsp),
      .rsp     (rsp_next)
   );

   assign rsp_valid_in = (step && has_rsp) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && has_rsp) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_id_zero_when_not_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.id_valid || rsp_payload.item_id == '0))
      else $error("item_id nonzero without id_valid");

   a_found_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.found || rsp_payload.done_res))
      else $error("found without done_res");

   a_absent_fails: assert property (@(posedge clock) disable iff (reset)
      (step && req_payload.req_type == REQ_START && !req_payload.record_present)
      |=> (rsp_valid && rsp_payload.done_res && !rsp_payload.found
           && !rsp_payload.id_valid))
      else $error("absent record did not report failure");

endmodule
`default_nettype wire

// ===== tb/record_id_list_extractor_core_tb.sv =====
`default_nettype none
module record_id_list_extractor_core_tb;
   import rlx_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned MAX_SHOWN = 40;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_FAIL,
      OUT_DONE
   } parse_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rlx_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rlx_rsp_type rsp_payload;

   record_id_list_extractor_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parse state of the predictor
   rlx_phase_type ph = PH_IDLE;
   logic [SIZE_WIDTH-1:0] left_bytes = '0;
   logic [SKIP_WIDTH-1:0] skip_left = '0;
   logic [7:0] len_low = '0;
   logic [COUNT_WIDTH-1:0] ids_to_go = '0;
   logic [ID_WIDTH-1:0] id_build = '0;
   logic [2:0] id_byte = '0;

   rlx_rsp_type expected_rsp[$];
   int unsigned fail_count = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned cur_send_pct = 0;
   int unsigned cur_stall_pct = 0;
   int unsigned phase_send_pct = 0;
   int unsigned phase_stall_pct = 0;

   function automatic void push_rsp(logic [63:0] id, logic v, logic d, logic f);
      rlx_rsp_type r;
      r.item_id = id;
      r.id_valid = v;
      r.done_res = d;
      r.found = f;
      expected_rsp = {expected_rsp, r};
   endfunction

   function automatic parse_outcome_type open_count(rlx_phase_type next_ph);
      if (left_bytes < 2) begin
         ph = PH_IDLE;
         return OUT_FAIL;
      end
      ph = next_ph;
      return OUT_NONE;
   endfunction

   function automatic parse_outcome_type open_fixed();
      if (FIXED_SKIP > left_bytes) begin
         ph = PH_IDLE;
         return OUT_FAIL;
      end
      if (FIXED_SKIP == 0)
         return open_count(PH_SKC_LO);
      skip_left = SKIP_WIDTH'(FIXED_SKIP);
      ph = PH_FIXED;
      return OUT_NONE;
   endfunction

   function automatic void predict_ids(rlx_req_type it);
      parse_outcome_type oc;
      logic [15:0] word;
      logic [63:0] id;
      logic last;
      oc = OUT_NONE;
      if (it.req_type == REQ_START) begin
         if (it.record_present == 1'b0) begin
            ph = PH_IDLE;
            push_rsp('0, 1'b0, 1'b1, 1'b0);
            return;
         end
         left_bytes = it.record_size;
         skip_left = '0;
         len_low = '0;
         ids_to_go = '0;
         id_build = '0;
         id_byte = '0;
         oc = open_count(PH_STR_LO);
      end else if (ph != PH_IDLE) begin
         if (left_bytes != 0)
            left_bytes = left_bytes - 1'b1;
         word = {it.data_byte, len_low};
         case (ph)
            PH_STR_LO, PH_SKC_LO, PH_LST_LO: begin
               len_low = it.data_byte;
               ph = rlx_phase_type'(ph + 1);
            end
            PH_STR_HI: begin
               if (word > left_bytes) begin
                  ph = PH_IDLE;
                  oc = OUT_FAIL;
               end else if (word == 0) begin
                  oc = open_fixed();
               end else begin
                  skip_left = SKIP_WIDTH'(word);
                  ph = PH_STR_SKIP;
               end
            end
            PH_STR_SKIP, PH_FIXED, PH_SKIP_IDS: begin
               if (skip_left != 0)
                  skip_left = skip_left - 1'b1;
               if (skip_left == 0) begin
                  if (ph == PH_STR_SKIP)
                     oc = open_fixed();
                  else if (ph == PH_FIXED)
                     oc = open_count(PH_SKC_LO);
                  else
                     oc = open_count(PH_LST_LO);
               end
            end
            PH_SKC_HI: begin
               if (word > (left_bytes >> 3)) begin
                  ph = PH_IDLE;
                  oc = OUT_FAIL;
               end else if (word == 0) begin
                  oc = open_count(PH_LST_LO);
               end else begin
                  skip_left = {1'b0, word, 3'b000};
                  ph = PH_SKIP_IDS;
               end
            end
            PH_LST_HI: begin
               if (word > (left_bytes >> 3)) begin
                  ph = PH_IDLE;
                  oc = OUT_FAIL;
               end else if (word == 0) begin
                  ph = PH_IDLE;
                  oc = OUT_DONE;
               end else begin
                  ids_to_go = word;
                  id_build = '0;
                  id_byte = '0;
                  ph = PH_LST_IDS;
               end
            end
            PH_LST_IDS: begin
               id_build = id_build | ({56'd0, it.data_byte} << (8 * id_byte));
               if (id_byte == 3'd7) begin
                  id = id_build;
                  id_byte = '0;
                  id_build = '0;
                  if (ids_to_go != 0)
                     ids_to_go = ids_to_go - 1'b1;
                  last = (ids_to_go == 0);
                  if (last)
                     ph = PH_IDLE;
                  push_rsp(id, 1'b1, last, last);
                  return;
               end
               id_byte = id_byte + 1'b1;
            end
            default: ;
         endcase
      end
      if (oc == OUT_FAIL)
         push_rsp('0, 1'b0, 1'b1, 1'b0);
      else if (oc == OUT_DONE)
         push_rsp('0, 1'b0, 1'b1, 1'b1);
   endfunction

   // results are checked before the item accepted at the same edge is predicted
   always @(posedge clock) begin
      rlx_rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("%0t: unexpected result: id %h valid %b done %b found %b", $time,
                     rsp_payload.item_id, rsp_payload.id_valid, rsp_payload.done_res,
                     rsp_payload.found);
            end else begin
               exp_rsp = expected_rsp.pop_front();
               if (rsp_payload.item_id !== exp_rsp.item_id
                     || rsp_payload.id_valid !== exp_rsp.id_valid
                     || rsp_payload.done_res !== exp_rsp.done_res
                     || rsp_payload.found !== exp_rsp.found) begin
                  fail_count++;
                  if (fail_count <= MAX_SHOWN)
                     $display("%0t: mismatch: exp id %h v %b d %b f %b, got id %h v %b d %b f %b",
                        $time, exp_rsp.item_id, exp_rsp.id_valid, exp_rsp.done_res,
                        exp_rsp.found, rsp_payload.item_id, rsp_payload.id_valid,
                        rsp_payload.done_res, rsp_payload.found);
               end
            end
         end
         if (req_valid && req_ready)
            predict_ids(req_payload);
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= cur_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("record_id_list_extractor_core test failed");
         $finish;
      end
   end

   task automatic send_item(input rlx_req_type it);
      while ($urandom_range(99) < cur_send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_start(input logic present, input logic [23:0] size);
      rlx_req_type it;
      it.req_type = REQ_START;
      it.record_present = present;
      it.record_size = size;
      it.data_byte = 8'($urandom);
      send_item(it);
   endtask

   task automatic send_byte(input logic [7:0] b);
      rlx_req_type it;
      it.req_type = REQ_BYTE;
      it.record_present = 1'($urandom);
      it.record_size = 24'($urandom);
      it.data_byte = b;
      send_item(it);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // one record: mostly well formed, some short, corrupted, cut off, absent or noise
   task automatic send_record();
      logic [7:0] body[$];
      logic [15:0] str_len;
      logic [15:0] n_skip;
      logic [15:0] n_ids;
      logic [15:0] fake;
      logic [63:0] id;
      logic [23:0] size;
      int unsigned flavor;
      int unsigned skip_pos;
      int unsigned list_pos;
      int unsigned exact_len;
      int unsigned keep;
      if ($urandom_range(11) == 0)
         wait_drained();
      cur_send_pct = ($urandom_range(3) == 0) ? 0 : phase_send_pct;
      cur_stall_pct = ($urandom_range(3) == 0) ? 0 : phase_stall_pct;
      flavor = $urandom_range(99);
      if (flavor >= 94) begin
         if (flavor < 97)
            send_start(1'b0, 24'($urandom));
         else
            send_start(1'($urandom), 24'($urandom));
         repeat ($urandom_range(6)) send_byte(8'($urandom));
         return;
      end
      case ($urandom_range(9))
         0: str_len = 16'd0;
         1, 2: str_len = 16'($urandom_range(60, 13));
         default: str_len = 16'($urandom_range(12));
      endcase
      n_skip = 16'($urandom_range(3));
      n_ids = 16'($urandom_range(4));
      body = {body, str_len[7:0]};
      body = {body, str_len[15:8]};
      repeat (str_len) body = {body, 8'($urandom)};
      repeat (FIXED_SKIP) body = {body, 8'($urandom)};
      skip_pos = body.size();
      body = {body, n_skip[7:0]};
      body = {body, n_skip[15:8]};
      repeat (8 * n_skip) body = {body, 8'($urandom)};
      list_pos = body.size();
      body = {body, n_ids[7:0]};
      body = {body, n_ids[15:8]};
      repeat (n_ids) begin
         case ($urandom_range(7))
            0: id = '1;
            1: id = '0;
            default: id = {$urandom, $urandom};
         endcase
         for (int k = 0; k < 8; k++)
            body = {body, id[8*k +: 8]};
      end
      exact_len = body.size();
      repeat ($urandom_range(3)) body = {body, 8'($urandom)};
      size = 24'(body.size());
      keep = body.size();
      if (flavor >= 70 && flavor < 80) begin
         size = 24'($urandom_range(exact_len - 1));
      end else if (flavor >= 80 && flavor < 88) begin
         // count fields larger than the bytes behind them
         if ($urandom_range(1)) begin
            fake = 16'($urandom_range(16'hFFFF, n_ids + 1));
            body[list_pos] = fake[7:0];
            body[list_pos+1] = fake[15:8];
         end else begin
            fake = 16'($urandom_range(16'hFFFF, n_skip + 1));
            body[skip_pos] = fake[7:0];
            body[skip_pos+1] = fake[15:8];
         end
      end else if (flavor >= 88) begin
         keep = $urandom_range(body.size() - 1);
      end
      send_start(1'b1, size);
      for (int k = 0; k < keep; k++)
         send_byte(body[k]);
   endtask

   task automatic run_records(input int unsigned send_pct, input int unsigned stall_pct,
                              input int unsigned n_items);
      int unsigned stop_at;
      stop_at = items_sent + n_items;
      phase_send_pct = send_pct;
      phase_stall_pct = stall_pct;
      while (items_sent < stop_at)
         send_record();
      wait_drained();
   endtask

   task automatic test_short_records();
      send_byte(8'hFF);                 // byte with no record open
      send_start(1'b0, 24'hFFFFFF);     // absent record
      send_start(1'b1, 24'd0);
      send_start(1'b1, 24'd1);
      // largest size and longest string, then abandoned by the next start
      send_start(1'b1, 24'hFFFFFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_start(1'b1, 24'd3);          // string longer than what is left
      send_byte(8'h02);
      send_byte(8'h00);
      send_start(1'b1, 24'd2);
      send_byte(8'h01);
      send_byte(8'h00);
      send_start(1'b1, 24'd4);          // fixed block does not fit
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      wait_drained();
   endtask

   task automatic test_records_back_to_back();
      run_records(0, 0, 320);
   endtask

   task automatic test_records_sender_gaps();
      run_records(78, 0, 300);
   endtask

   task automatic test_records_receiver_stalls();
      run_records(0, 78, 300);
   endtask

   task automatic test_records_both_idle();
      run_records(34, 34, 300);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_short_records();
      test_records_back_to_back();
      test_records_sender_gaps();
      test_records_receiver_stalls();
      test_records_both_idle();
      cur_stall_pct = 0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_rsp.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("record_id_list_extractor_core test passed");
      else
         $display("record_id_list_extractor_core test failed");
      $finish;
   end

endmodule
`default_nettype wire
